// ===== rtl/circ_pkg.sv =====
// ----------------------------------------------------------------------------
// circ_pkg
// shared widths, codes and the step snapshot type of the circle rasterizer
// ----------------------------------------------------------------------------
package circ_pkg;

  localparam int CENTER_W = 12;   // signed center coordinate
  localparam int RADIUS_W = 10;
  localparam int OFS_W    = 11;   // signed x / y offset
  localparam int DEC_W    = 16;   // signed decision, wraps
  localparam int COORD_W  = 14;   // signed point coordinate, center plus offset
  localparam int PIX_W    = 9;
  localparam int COLOR_W  = 8;
  localparam int POINTS   = 8;
  localparam int IDX_W    = 3;

  localparam int FRAME_WIDTH_DEF  = 512;
  localparam int FRAME_HEIGHT_DEF = 512;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);

  // everything the point generator needs for one step
  typedef struct packed {
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
    logic signed [OFS_W-1:0]    x;
    logic signed [OFS_W-1:0]    y;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
    logic                       done;
  } job_t;

endpackage

// ===== rtl/circ_step.sv =====
// ----------------------------------------------------------------------------
// circ_step
// circle state and midpoint decision update, one input beat per cycle on fire
// ----------------------------------------------------------------------------
module circ_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  logic                                 cmd,
  input  logic signed [circ_pkg::CENTER_W-1:0] center_x,
  input  logic signed [circ_pkg::CENTER_W-1:0] center_y,
  input  logic [circ_pkg::RADIUS_W-1:0]        radius,
  input  logic [circ_pkg::COLOR_W-1:0]         red,
  input  logic [circ_pkg::COLOR_W-1:0]         green,
  input  logic [circ_pkg::COLOR_W-1:0]         blue,
  output circ_pkg::job_t                       job,
  output logic                                 job_load
);

  logic signed [circ_pkg::CENTER_W-1:0] center_col_reg;
  logic signed [circ_pkg::CENTER_W-1:0] center_y_reg;
  logic signed [circ_pkg::OFS_W-1:0]    x_offset;
  logic signed [circ_pkg::OFS_W-1:0]    y_offset;
  logic signed [circ_pkg::DEC_W-1:0]    decision;
  logic [circ_pkg::COLOR_W-1:0]         red_reg;
  logic [circ_pkg::COLOR_W-1:0]         green_reg;
  logic [circ_pkg::COLOR_W-1:0]         blue_reg;
  logic                                 active;

  logic signed [circ_pkg::OFS_W-1:0] y_dec;
  logic signed [circ_pkg::OFS_W-1:0] x_offset_next;
  logic signed [circ_pkg::OFS_W-1:0] y_offset_next;
  logic signed [circ_pkg::DEC_W-1:0] dec_mid;
  logic signed [circ_pkg::DEC_W-1:0] decision_next;
  logic signed [circ_pkg::DEC_W-1:0] dec_start;
  logic                              done;

  always_comb begin
    y_dec         = y_offset - circ_pkg::OFS_W'(1);
    x_offset_next = x_offset + circ_pkg::OFS_W'(1);
    if (decision > circ_pkg::DEC_W'(0)) begin
      y_offset_next = y_dec;
      dec_mid = decision + circ_pkg::DEC_W'(2)
                - (circ_pkg::DEC_W'(y_dec) <<< 1);
    end else begin
      y_offset_next = y_offset;
      dec_mid       = decision;
    end
    decision_next = dec_mid + (circ_pkg::DEC_W'(x_offset_next) <<< 1)
                    + circ_pkg::DEC_W'(3);
    done      = x_offset_next > y_offset_next;
    dec_start = circ_pkg::DEC_W'(3)
                - (circ_pkg::DEC_W'(radius) << 1);
  end

  // snapshot of the pair before its update
  always_comb begin
    job.cx    = center_col_reg;
    job.cy    = center_y_reg;
    job.x     = x_offset;
    job.y     = y_offset;
    job.red   = red_reg;
    job.green = green_reg;
    job.blue  = blue_reg;
    job.done  = done;
  end

  assign job_load = fire && (cmd == circ_pkg::CMD_STEP) && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col_reg <= '0;
      center_y_reg   <= '0;
      x_offset       <= '0;
      y_offset       <= '0;
      decision       <= '0;
      red_reg        <= '0;
      green_reg      <= '0;
      blue_reg       <= '0;
      active         <= 1'b0;
    end else if (fire && (cmd == circ_pkg::CMD_START)) begin
      center_col_reg <= center_x;
      center_y_reg   <= center_y;
      x_offset       <= '0;
      y_offset       <= circ_pkg::OFS_W'(radius);
      decision       <= dec_start;
      red_reg        <= red;
      green_reg      <= green;
      blue_reg       <= blue;
      active         <= 1'b1;
    end else if (job_load) begin
      x_offset <= x_offset_next;
      y_offset <= y_offset_next;
      decision <= decision_next;
      if (done) begin
        active <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/circ_point.sv =====
// ----------------------------------------------------------------------------
// circ_point
// eight-way symmetric point generator with frame clipping and output register
// ----------------------------------------------------------------------------
module circ_point #(
  parameter int FRAME_WIDTH  = circ_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = circ_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  circ_pkg::job_t                   job,
  input  logic                             job_load,
  output logic                             ready,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [circ_pkg::PIX_W-1:0]       pixel_col,
  output logic [circ_pkg::PIX_W-1:0]       pixel_row,
  output logic [circ_pkg::COLOR_W-1:0]     out_red,
  output logic [circ_pkg::COLOR_W-1:0]     out_green,
  output logic [circ_pkg::COLOR_W-1:0]     out_blue,
  output logic                             write_enable,
  output logic                             last_of_step,
  output logic                             circle_done
);

  localparam logic signed [circ_pkg::COORD_W-1:0] FW = circ_pkg::COORD_W'(FRAME_WIDTH);
  localparam logic signed [circ_pkg::COORD_W-1:0] FH = circ_pkg::COORD_W'(FRAME_HEIGHT);

  circ_pkg::job_t                  job_q;
  logic                            busy;
  logic [circ_pkg::IDX_W-1:0]      idx;

  logic                                  advance;
  logic                                  last;
  logic signed [circ_pkg::OFS_W-1:0]     ofs_a;
  logic signed [circ_pkg::OFS_W-1:0]     ofs_b;
  logic signed [circ_pkg::COORD_W-1:0]   a_ext;
  logic signed [circ_pkg::COORD_W-1:0]   b_ext;
  logic signed [circ_pkg::COORD_W-1:0]   col;
  logic signed [circ_pkg::COORD_W-1:0]   yy;
  logic signed [circ_pkg::COORD_W-1:0]   row;
  logic                                  in_frame;

  assign advance = busy && (!out_valid || !out_stall);
  assign last    = (idx == circ_pkg::IDX_LAST);
  assign ready   = !busy || (advance && last);

  // idx[2] swaps x and y, idx[0] negates the column term, idx[1] the row term
  always_comb begin
    ofs_a    = idx[2] ? job_q.y : job_q.x;
    ofs_b    = idx[2] ? job_q.x : job_q.y;
    a_ext    = circ_pkg::COORD_W'(ofs_a);
    b_ext    = circ_pkg::COORD_W'(ofs_b);
    col      = circ_pkg::COORD_W'(job_q.cx) + (idx[0] ? -a_ext : a_ext);
    yy       = circ_pkg::COORD_W'(job_q.cy) + (idx[1] ? -b_ext : b_ext);
    row      = FH - circ_pkg::COORD_W'(1) - yy;
    in_frame = (col >= circ_pkg::COORD_W'(0)) && (col < FW)
               && (yy >= circ_pkg::COORD_W'(0)) && (yy < FH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_load) begin
      busy  <= 1'b1;
      idx   <= '0;
      job_q <= job;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + circ_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid    <= 1'b1;
      pixel_col    <= in_frame ? col[circ_pkg::PIX_W-1:0] : '0;
      pixel_row    <= in_frame ? row[circ_pkg::PIX_W-1:0] : '0;
      out_red      <= job_q.red;
      out_green    <= job_q.green;
      out_blue     <= job_q.blue;
      write_enable <= in_frame;
      last_of_step <= last;
      circle_done  <= last && job_q.done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// circle_rasterizer
// midpoint circle pixel generator, eight clipped points per step command
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   cmd, center_x, center_y, radius,
//                                             red, green, blue
//   out      source     out_valid / out_stall pixel_col, pixel_row, out_red,
//                                             out_green, out_blue, write_enable,
//                                             last_of_step, circle_done
//
// a start beat or an ignored step beat gives no result
// a step beat gives eight result beats, one per cycle while out_stall is low;
// the point generator walks its eight symmetric points before taking a new step
// the next step is taken in the cycle its predecessor's last point moves out
// rst is synchronous; it drops any circle and any pending point
// out_stall holds the output register and, once the generator is full, in_stall
// ----------------------------------------------------------------------------
module circle_rasterizer #(
  parameter int FRAME_WIDTH  = circ_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = circ_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [circ_pkg::CENTER_W-1:0] center_x,
  input  logic signed [circ_pkg::CENTER_W-1:0] center_y,
  input  logic [circ_pkg::RADIUS_W-1:0]        radius,
  input  logic [circ_pkg::COLOR_W-1:0]         red,
  input  logic [circ_pkg::COLOR_W-1:0]         green,
  input  logic [circ_pkg::COLOR_W-1:0]         blue,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [circ_pkg::PIX_W-1:0]           pixel_col,
  output logic [circ_pkg::PIX_W-1:0]           pixel_row,
  output logic [circ_pkg::COLOR_W-1:0]         out_red,
  output logic [circ_pkg::COLOR_W-1:0]         out_green,
  output logic [circ_pkg::COLOR_W-1:0]         out_blue,
  output logic                                 write_enable,
  output logic                                 last_of_step,
  output logic                                 circle_done
);

  circ_pkg::job_t job;
  logic           job_load;
  logic           ready;
  logic           fire;

  // a beat is taken whenever the point generator can take a fresh step
  assign in_stall = !ready;
  assign fire     = in_valid && !in_stall;

  // circle state, decision update, step snapshot
  circ_step u_step (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .cmd      (cmd),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .job      (job),
    .job_load (job_load)
  );

  // octant mirroring, frame clipping, result register
  circ_point #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_point (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .job_load     (job_load),
    .ready        (ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .write_enable (write_enable),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

// ===== rtl/circ_checker.sv =====
// ----------------------------------------------------------------------------
// circ_checker
// port-level checks on the circle rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module circ_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [circ_pkg::PIX_W-1:0]      pixel_col,
  input logic [circ_pkg::PIX_W-1:0]      pixel_row,
  input logic                            write_enable,
  input logic                            last_of_step,
  input logic                            circle_done
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_col)
      && $stable(pixel_row) && $stable(write_enable) && $stable(last_of_step))
    else $error("result beat changed while stalled");

  // walk end only flagged on the eighth point
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && circle_done |-> last_of_step)
    else $error("circle_done without last_of_step");

  // clipped points carry zero coordinates
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_col == '0 && pixel_row == '0)
    else $error("clipped point with non-zero coordinates");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind circle_rasterizer circ_checker u_circ_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_col    (pixel_col),
  .pixel_row    (pixel_row),
  .write_enable (write_enable),
  .last_of_step (last_of_step),
  .circle_done  (circle_done)
);
